FILE: src/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// shared constants, types and codes of the row box blur
// ----------------------------------------------------------------------------
package rbb_pkg;

    localparam int MAX_RADIUS   = 31;
    localparam int MAX_WIDTH    = 4096;
    localparam int CHANNEL_BITS = 16;

    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int PIX_BITS  = 3 * CHANNEL_BITS;
    localparam int RAD_BITS  = 5;
    localparam int SIZE_BITS = 13;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int DIV_BITS  = $clog2(WIN_DEPTH + 1);
    localparam int SUM_BITS  = CHANNEL_BITS + DIV_BITS;
    localparam int K_BITS    = COL_BITS + 2;
    localparam int CNT_BITS  = $clog2(SUM_BITS);
    localparam int REG_BITS  = 2;

    typedef enum logic [REG_BITS-1:0] {
        REG_RADIUS,
        REG_ROW_WIDTH,
        REG_IMAGE_HEIGHT
    } reg_idx_t;

    typedef struct packed {
        logic [RAD_BITS-1:0] radius;
        logic [COL_BITS-1:0] wm1;
        logic [COL_BITS-1:0] hm1;
    } cfg_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic [COL_BITS-1:0] col;
        logic [WIN_AW-1:0]   addr;
        logic                has_emit;
        logic [COL_BITS-1:0] j_first;
        logic [COL_BITS-1:0] j_last;
        logic                frame_done;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SUM,
        BK_TAIL,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

FILE: src/rbb_ram.sv
// ----------------------------------------------------------------------------
// rbb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/rbb_front.sv
// ----------------------------------------------------------------------------
// rbb_front
// tracks column and row, classifies each pixel into a job for the back end
// ----------------------------------------------------------------------------
module rbb_front import rbb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PIX_BITS-1:0] s_pixel,
    input  logic                q_full,
    output logic                q_push,
    output job_t                q_job
);

    logic [COL_BITS-1:0] col_reg, col_next;
    logic [COL_BITS-1:0] row_reg, row_next;
    logic [WIN_AW-1:0]   addr_reg, addr_next;
    logic                row_end;
    logic                frame_done;
    logic                col_ge_r;
    logic [COL_BITS-1:0] r_ext;

    assign s_ready    = !q_full;
    assign q_push     = s_valid && !q_full;
    assign r_ext      = COL_BITS'(cfg.radius);
    assign row_end    = col_reg >= cfg.wm1;
    assign frame_done = row_reg >= cfg.hm1;
    assign col_ge_r   = col_reg >= r_ext;

    always_comb begin
        q_job.pixel      = s_pixel;
        q_job.col        = col_reg;
        q_job.addr       = addr_reg;
        q_job.has_emit   = row_end || col_ge_r;
        q_job.j_first    = col_ge_r ? col_reg - r_ext : '0;
        q_job.j_last     = row_end ? col_reg : col_reg - r_ext;
        q_job.frame_done = row_end && frame_done;

        col_next  = col_reg;
        row_next  = row_reg;
        addr_next = addr_reg;
        if (q_push) begin
            if (row_end) begin
                col_next  = '0;
                addr_next = '0;
                row_next  = frame_done ? '0 : row_reg + 1'b1;
            end else begin
                col_next  = col_reg + 1'b1;
                addr_next = (addr_reg == WIN_AW'(WIN_DEPTH - 1)) ? '0 : addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            addr_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            addr_reg <= addr_next;
        end
    end

endmodule

FILE: src/rbb_queue.sv
// ----------------------------------------------------------------------------
// rbb_queue
// two entry job queue between front and back end
// ----------------------------------------------------------------------------
module rbb_queue import rbb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/rbb_back.sv
// ----------------------------------------------------------------------------
// rbb_back
// stores pixels, sums each window from the pixel ram, divides, sends results
// ----------------------------------------------------------------------------
module rbb_back import rbb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                q_empty,
    output logic                q_pop,
    input  job_t                q_job,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [PIX_BITS-1:0] m_pixel,
    output logic                m_last,
    output logic                m_frame_end
);

    back_state_t state_reg, state_next;
    job_t                job_reg, job_next;
    logic [PIX_BITS-1:0] first_reg, first_next;
    logic [COL_BITS-1:0] j_reg, j_next;
    logic signed [K_BITS-1:0] k_reg, k_next;
    logic [DIV_BITS-1:0] term_reg, term_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                use_first_reg, use_first_next;
    logic [SUM_BITS-1:0] acc_reg [3];
    logic [SUM_BITS-1:0] acc_next [3];
    logic [SUM_BITS-1:0] acc_sum [3];
    logic [DIV_BITS-1:0] rem_reg [3];
    logic [DIV_BITS-1:0] rem_next [3];
    logic [SUM_BITS-1:0] quo_reg [3];
    logic [SUM_BITS-1:0] quo_next [3];
    logic [DIV_BITS:0]   rem_shift [3];
    logic                rem_ge [3];
    logic [CNT_BITS-1:0] div_cnt_reg, div_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [PIX_BITS-1:0] out_pixel_reg, out_pixel_next;
    logic                out_last_reg, out_last_next;
    logic                out_fend_reg, out_fend_next;
    logic                out_load;

    logic                ram_we;
    logic [WIN_AW-1:0]   ram_raddr;
    logic [PIX_BITS-1:0] ram_rdata;

    logic [DIV_BITS-1:0] divisor;
    logic [DIV_BITS-1:0] two_r;
    logic signed [K_BITS-1:0] r_k;
    logic signed [K_BITS-1:0] col_k;
    logic [COL_BITS-1:0] pos;
    logic [WIN_AW-1:0]   diff;
    logic [WIN_AW:0]     addr_wide;
    logic [PIX_BITS-1:0] term_pix;
    logic signed [K_BITS-1:0] k_start_next;

    rbb_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (WIN_DEPTH)
    ) u_win_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_job.addr),
        .wdata (q_job.pixel),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign two_r   = {cfg.radius, 1'b0};
    assign divisor = {cfg.radius, 1'b1};
    assign r_k     = $signed({{(K_BITS-RAD_BITS){1'b0}}, cfg.radius});
    assign col_k   = $signed({2'b00, job_reg.col});

    // clamped position and its ram address, relative to the job's column
    always_comb begin
        pos       = (k_reg > col_k) ? job_reg.col : k_reg[COL_BITS-1:0];
        diff      = WIN_AW'(job_reg.col - pos);
        addr_wide = ({1'b0, job_reg.addr} >= {1'b0, diff})
                  ? {1'b0, job_reg.addr} - {1'b0, diff}
                  : {1'b0, job_reg.addr} + (WIN_AW+1)'(WIN_DEPTH) - {1'b0, diff};
        ram_raddr = addr_wide[WIN_AW-1:0];
        term_pix  = use_first_reg ? first_reg : ram_rdata;
        for (int ch = 0; ch < 3; ch++) begin
            acc_sum[ch]   = acc_reg[ch]
                          + SUM_BITS'(term_pix[ch*CHANNEL_BITS +: CHANNEL_BITS]);
            rem_shift[ch] = {rem_reg[ch], quo_reg[ch][SUM_BITS-1]};
            rem_ge[ch]    = rem_shift[ch] >= {1'b0, divisor};
        end
        k_start_next = $signed({2'b00, j_reg + 1'b1}) - r_k;
    end

    assign out_load = (state_reg == BK_OUT) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        first_next     = first_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        term_next      = term_reg;
        rd_valid_next  = 1'b0;
        use_first_next = use_first_reg;
        div_cnt_next   = div_cnt_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        out_pixel_next = out_pixel_reg;
        out_last_next  = out_last_reg;
        out_fend_next  = out_fend_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    ram_we   = 1'b1;
                    job_next = q_job;
                    if (q_job.col == '0) begin
                        first_next = q_job.pixel;
                    end
                    if (q_job.has_emit) begin
                        j_next     = q_job.j_first;
                        k_next     = $signed({2'b00, q_job.j_first}) - r_k;
                        term_next  = two_r;
                        for (int ch = 0; ch < 3; ch++) acc_next[ch] = '0;
                        state_next = BK_SUM;
                    end
                end
            end
            BK_SUM: begin
                rd_valid_next  = 1'b1;
                use_first_next = k_reg <= 0;
                if (rd_valid_reg) begin
                    acc_next = acc_sum;
                end
                k_next    = k_reg + 1'b1;
                term_next = term_reg - 1'b1;
                if (term_reg == '0) begin
                    state_next = BK_TAIL;
                end
            end
            BK_TAIL: begin
                for (int ch = 0; ch < 3; ch++) begin
                    quo_next[ch] = acc_sum[ch];
                    rem_next[ch] = '0;
                end
                div_cnt_next = '0;
                state_next   = BK_DIV;
            end
            BK_DIV: begin
                for (int ch = 0; ch < 3; ch++) begin
                    rem_next[ch] = rem_ge[ch]
                                 ? DIV_BITS'(rem_shift[ch] - {1'b0, divisor})
                                 : rem_shift[ch][DIV_BITS-1:0];
                    quo_next[ch] = {quo_reg[ch][SUM_BITS-2:0], rem_ge[ch]};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CNT_BITS'(SUM_BITS - 1)) begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    for (int ch = 0; ch < 3; ch++) begin
                        out_pixel_next[ch*CHANNEL_BITS +: CHANNEL_BITS] =
                            quo_reg[ch][CHANNEL_BITS-1:0];
                    end
                    out_last_next = j_reg == job_reg.j_last;
                    out_fend_next = (j_reg == job_reg.j_last) && job_reg.frame_done;
                    if (j_reg == job_reg.j_last) begin
                        state_next = BK_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        k_next     = k_start_next;
                        term_next  = two_r;
                        for (int ch = 0; ch < 3; ch++) acc_next[ch] = '0;
                        state_next = BK_SUM;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg        <= job_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        term_reg       <= term_next;
        use_first_reg  <= use_first_next;
        div_cnt_reg    <= div_cnt_next;
        acc_reg        <= acc_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        out_pixel_reg  <= out_pixel_next;
        out_last_reg   <= out_last_next;
        out_fend_reg   <= out_fend_next;
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            first_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel     = out_pixel_reg;
    assign m_last      = out_last_reg;
    assign m_frame_end = out_fend_reg;

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_DIV |-> div_cnt_reg < CNT_BITS'(SUM_BITS))
        else $error("divider step count out of range");

    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_last)
        else $error("frame end without run last");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == BK_IDLE && !q_empty)
        else $error("job popped outside idle");

    a_tail_after_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_TAIL |-> $past(state_reg) == BK_SUM && rd_valid_reg)
        else $error("window sum tail without pending read");

endmodule

FILE: src/row_box_blur_clamped.sv
// ----------------------------------------------------------------------------
// row_box_blur_clamped
// row box blur with edge replication on a stream of rgb pixels
// ----------------------------------------------------------------------------
// channel  direction  tdata (low bit up)          tlast     tuser
// s_axis   in         red, green, blue            -         -
// m_axis   out        red, green, blue            run last  frame end
// cfg      in         index 0 radius, 1 row_width, 2 image_height
//
// a pixel that causes no result is taken in the back end's idle state
// each result takes 2r+1 window reads, a tail step, 22 divider steps and an
// output step that can wait on the receiver, the first also the idle pop of its pixel
// the window sum reads the pixel ram one entry per cycle
// synchronous active low reset, no clearing pass
// a two entry job queue lets input run ahead while results are stalled
// ----------------------------------------------------------------------------
module row_box_blur_clamped import rbb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_BITS-1:0]  cfg_wr_index,
    input  logic [SIZE_BITS-1:0] cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_BITS-1:0]  s_axis_tdata,  // red_in, green_in, blue_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_BITS-1:0]  m_axis_tdata,  // red_out, green_out, blue_out
    output logic                 m_axis_tlast,
    output logic                 m_axis_tuser   // frame_end
);

    logic [RAD_BITS-1:0]  radius_reg;
    logic [SIZE_BITS-1:0] row_width_reg;
    logic [SIZE_BITS-1:0] image_height_reg;
    cfg_t                 cfg;
    logic                 q_full, q_empty, q_push, q_pop;
    job_t                 push_job, pop_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg       <= RAD_BITS'(1);
            row_width_reg    <= SIZE_BITS'(640);
            image_height_reg <= SIZE_BITS'(480);
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_wr_index))
                REG_RADIUS:       radius_reg       <= cfg_wr_data[RAD_BITS-1:0];
                REG_ROW_WIDTH:    row_width_reg    <= cfg_wr_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.radius = (radius_reg > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS) : radius_reg;
        if (row_width_reg == '0) begin
            cfg.wm1 = '0;
        end else if (row_width_reg > SIZE_BITS'(MAX_WIDTH)) begin
            cfg.wm1 = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            cfg.wm1 = COL_BITS'(row_width_reg - 1'b1);
        end
        if (image_height_reg == '0) begin
            cfg.hm1 = '0;
        end else if (image_height_reg > SIZE_BITS'(MAX_WIDTH)) begin
            cfg.hm1 = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            cfg.hm1 = COL_BITS'(image_height_reg - 1'b1);
        end
    end

    rbb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_pixel (s_axis_tdata),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    rbb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    rbb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_job       (pop_job),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_pixel     (m_axis_tdata),
        .m_last      (m_axis_tlast),
        .m_frame_end (m_axis_tuser)
    );

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the row box blur: a directed table and random
// rows are streamed in, every result is checked against a predictor of
// the edge-replicated row mean, with sender and receiver idling in phases
// ----------------------------------------------------------------------------
module tb;
    import rbb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] r, g, b;
        logic        run_last, frame_end;
    } blur_out_t;

    typedef struct {
        logic [47:0] pix;
        logic        chk;
        logic [47:0] exp_pix;
    } row_item_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [REG_BITS-1:0] cfg_wr_index = REG_RADIUS;
    logic [SIZE_BITS-1:0] cfg_wr_data = '0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [PIX_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [PIX_BITS-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;

    always #1 aclk = ~aclk;

    row_box_blur_clamped uut (.*);

    // predictor state
    int unsigned cur_radius = 1, cur_width = 640, cur_height = 480;
    logic [47:0] win_mem [WIN_DEPTH];
    logic [47:0] first_pix = '0;
    int unsigned col_cnt = 0, row_cnt = 0;

    blur_out_t blur_q[$];
    int errors = 0;
    int snd_idle = 0, rcv_idle = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic logic [47:0] window_pix(int k, int last);
        if (k <= 0) return first_pix;
        if (k > last) k = last;
        return win_mem[k % WIN_DEPTH];
    endfunction

    function automatic blur_out_t box_mean(int j, int last, int r);
        blur_out_t o;
        longint s [3];
        logic [47:0] p;
        s = '{0, 0, 0};
        for (int k = j - r; k <= j + r; k++) begin
            p = window_pix(k, last);
            for (int c = 0; c < 3; c++) s[c] += p[16*c +: 16];
        end
        o.r = 16'(s[0] / (2*r+1));
        o.g = 16'(s[1] / (2*r+1));
        o.b = 16'(s[2] / (2*r+1));
        o.run_last = 0;
        o.frame_end = 0;
        return o;
    endfunction

    function automatic int unsigned clamp_size(int unsigned v);
        if (v < 1) return 1;
        if (v > MAX_WIDTH) return MAX_WIDTH;
        return v;
    endfunction

    task automatic predict_pixel(input logic [47:0] pix);
        int r, c, j;
        int unsigned w, h;
        bit row_end, frame_done;
        blur_out_t o;
        int n0;
        r = cur_radius > MAX_RADIUS ? MAX_RADIUS : cur_radius;
        w = clamp_size(cur_width);
        h = clamp_size(cur_height);
        c = col_cnt;
        row_end = col_cnt + 1 >= w;
        frame_done = row_cnt + 1 >= h;
        n0 = blur_q.size();
        win_mem[col_cnt % WIN_DEPTH] = pix;
        if (c == 0) first_pix = pix;
        if (!row_end) begin
            if (c >= r) blur_q.insert(blur_q.size(), box_mean(c - r, c, r));
            col_cnt++;
        end else begin
            for (j = (c >= r) ? c - r : 0; j <= c; j++)
                blur_q.insert(blur_q.size(), box_mean(j, c, r));
            if (frame_done) blur_q[$].frame_end = 1;
            col_cnt = 0;
            row_cnt = frame_done ? 0 : row_cnt + 1;
        end
        if (blur_q.size() > n0) blur_q[$].run_last = 1;
    endtask

    // directed checks typed in by hand, consumed in order of results
    logic [47:0] typed_q[$];
    bit          typed_en[$];

    always @(posedge aclk) begin
        blur_out_t e;
        if (aresetn && s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (blur_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = blur_q.pop_front();
                if (m_axis_tdata !== {e.b, e.g, e.r})
                    report_mismatch($sformatf("pixel %h exp %h", m_axis_tdata,
                                              {e.b, e.g, e.r}));
                if (m_axis_tlast !== e.run_last) report_mismatch("tlast");
                if (m_axis_tuser !== e.frame_end) report_mismatch("tuser");
                if (typed_q.size() > 0) begin
                    if (typed_en[0] && m_axis_tdata !== typed_q[0])
                        report_mismatch("directed value");
                    void'(typed_q.pop_front());
                    void'(typed_en.pop_front());
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= (rcv_idle > 0 && $urandom_range(99) < rcv_idle) ? 1'b0 : 1'b1;
    end

    task automatic cfg_write(input reg_idx_t idx, input int unsigned val);
        s_axis_tvalid <= 0;
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_index <= idx;
        cfg_wr_data <= SIZE_BITS'(val);
        @(negedge aclk);
        cfg_wr_en <= 0;
        if (idx == REG_RADIUS) cur_radius = val & 5'h1f;
        else if (idx == REG_ROW_WIDTH) cur_width = val & 13'h1fff;
        else cur_height = val & 13'h1fff;
    endtask

    task automatic send_pixel(input logic [47:0] pix);
        while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= pix;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        while (blur_q.size() > 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    function automatic logic [47:0] rand_pix(int mode);
        logic [47:0] p;
        p = 48'({$urandom, $urandom});
        if (mode == 1) p = '1;
        if (mode == 2) p = '0;
        return p;
    endfunction

    row_item_t dir_tab[$];

    initial begin
        int w, m;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: radius 0 passes pixels through, width 1, height 1
        cfg_write(REG_RADIUS, 0);
        cfg_write(REG_ROW_WIDTH, 1);
        cfg_write(REG_IMAGE_HEIGHT, 1);
        dir_tab = '{'{48'hffff_ffff_ffff, 1, 48'hffff_ffff_ffff},
                    '{48'h0, 1, 48'h0},
                    '{48'h1234_5678_9abc, 1, 48'h1234_5678_9abc}};
        foreach (dir_tab[i]) begin
            typed_q.insert(typed_q.size(), dir_tab[i].exp_pix);
            typed_en.insert(typed_en.size(), dir_tab[i].chk);
            send_pixel(dir_tab[i].pix);
        end
        drain();
        // max radius, short rows of all-ones then zeros, frame of 2 rows
        cfg_write(REG_RADIUS, 31);
        cfg_write(REG_ROW_WIDTH, 5);
        cfg_write(REG_IMAGE_HEIGHT, 2);
        for (int i = 0; i < 5; i++) send_pixel('1);
        for (int i = 0; i < 5; i++) send_pixel('0);
        drain();
        // zero sizes count as one, oversize saturates
        cfg_write(REG_ROW_WIDTH, 0);
        cfg_write(REG_IMAGE_HEIGHT, 0);
        for (int i = 0; i < 3; i++) send_pixel(rand_pix(0));
        drain();
        cfg_write(REG_ROW_WIDTH, 8191);
        cfg_write(REG_IMAGE_HEIGHT, 8191);
        cfg_write(REG_RADIUS, 1);
        for (int i = 0; i < 4; i++) send_pixel(rand_pix(0));
        drain();
        // width lowered inside a row ends the row at once
        cfg_write(REG_ROW_WIDTH, 2);
        send_pixel(rand_pix(1));
        drain();

        // random rows over idling phases
        for (int ph = 0; ph < 4; ph++) begin
            snd_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 10 : 51) : 0;
            rcv_idle = (ph == 2 || ph == 3) ? (ph == 3 ? 10 : 51) : 0;
            for (int s = 0; s < 4; s++) begin
                w = $urandom_range(1, 20);
                if ($urandom_range(9) == 0) w = $urandom_range(60, 70);
                cfg_write(REG_ROW_WIDTH, w);
                cfg_write(REG_RADIUS, $urandom_range(3) == 0 ? 31 : $urandom_range(0, 6));
                cfg_write(REG_IMAGE_HEIGHT, $urandom_range(1, 3));
                m = 0;
                while (m < 23) begin
                    send_pixel(rand_pix($urandom_range(9) == 0 ? $urandom_range(1, 2) : 0));
                    m++;
                end
                drain();
            end
        end
        snd_idle = 0;
        rcv_idle = 0;
        drain();
        if (errors == 0) begin
            $display("[row_box_blur_clamped] OK");
        end else begin
            $display("[row_box_blur_clamped] ERROR");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("[row_box_blur_clamped] ERROR");
        $finish;
    end
endmodule
